FILE: rtl/assert_macros.svh
// Assertion macros shared by the handle table RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHK_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("check failed");

// Implication whose consequent is checked in the following cycle.
`define CHK_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("check failed");

`endif

FILE: rtl/ght_pkg.sv
// Package for the generational handle table: sizes, codes, shared types.
// No dependencies.
`timescale 1ns / 1ps
package ght_pkg;
  localparam int SLOTS    = 64;
  localparam int ITEMS    = 16;
  localparam int GEN_W    = 16;
  localparam int IDX_W    = $clog2(SLOTS);
  localparam int ITM_W    = $clog2(ITEMS);
  localparam int CNT_W    = $clog2(ITEMS + 1);
  localparam int TOP_W    = $clog2(SLOTS + 1);
  localparam int ADDR_W   = IDX_W + ITM_W;
  localparam int ENT_W    = 40;

  localparam logic [2:0] OP_CREATE  = 3'd0;
  localparam logic [2:0] OP_ALIVE   = 3'd1;
  localparam logic [2:0] OP_ADD     = 3'd2;
  localparam logic [2:0] OP_REMOVE  = 3'd3;
  localparam logic [2:0] OP_COUNT   = 3'd4;
  localparam logic [2:0] OP_CLEAN   = 3'd5;
  localparam logic [2:0] OP_DESTROY = 3'd6;
  localparam logic [2:0] OP_UNUSED  = 3'd7;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_STALE    = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_TFULL    = 3'd3;
  localparam logic [2:0] ST_SFULL    = 3'd4;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ENT_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;
endpackage

FILE: rtl/ght_ram.sv
// Item store RAM: one write and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
module ght_ram #(
  parameter int AW = 10,
  parameter int DW = 40
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [0:(1<<AW)-1];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

FILE: rtl/generational_handle_table.sv
// Top level of the generational handle table: slot table, free stack, sequencer.
// Depends on ght_pkg, ght_ram and assert_macros.svh.
//
// Channel | dir | contents
// in_     | in  | op, handle_index, handle_generation, item_kind, item_value
// out_    | out | status, new_index, new_generation, item_count, drained_*, tlast
//
// Sequence: create, count, is_alive, add and stale or unused ops pass through
// accept, slot lookup, execute and result taken before the next accept.
// Remove then reads and compares each stored item in turn.
// Clean and destroy add an output step per item; a waiting
// drained item stalls the walk. in_tready is low while busy or a result waits.
// Reset is synchronous; slot, free-stack and item memories are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module generational_handle_table
  import ght_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // op[2:0], handle_index[8:3], handle_generation[24:9], item_kind[32:25],
  // item_value[64:33], zero fill
  input  logic [71:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[2:0], new_index[8:3], new_generation[24:9], item_count[29:25],
  // drained_valid[30], drained_kind[38:31], drained_value[70:39], zero fill
  output logic [71:0]  out_tdata,
  output logic         out_tlast
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_LOOK = 3'd5;

  typedef struct packed {
    logic             live;
    logic [GEN_W-1:0] gen;
    logic [CNT_W-1:0] cnt;
  } slot_t;

  logic [2:0]        state_r, state_nxt;
  logic [2:0]        op_r;
  logic [IDX_W-1:0]  hidx_r;
  logic [GEN_W-1:0]  hgen_r;
  logic [ENT_W-1:0]  key_r;

  slot_t             slot_mem [SLOTS];
  logic [IDX_W-1:0]  fstk_mem [SLOTS];
  slot_t             slot_rd_r;
  logic [IDX_W-1:0]  fstk_rd_r;
  logic              slot_re;
  logic              slot_we;
  logic [IDX_W-1:0]  slot_raddr;
  logic [IDX_W-1:0]  slot_waddr;
  slot_t             slot_wdata;
  logic              fstk_re;
  logic              fstk_we;
  logic [TOP_W-1:0]  ftop_r;
  logic [TOP_W-1:0]  used_r;

  logic              valid_h_r;
  logic [CNT_W-1:0]  n_r;
  logic [CNT_W-1:0]  i_r;
  logic              found_r;

  logic              ov_r;
  logic [71:0]       od_r;
  logic              ol_r;

  mem_req_t          mreq;
  logic [ENT_W-1:0]  rdata;

  ght_ram #(.AW(ADDR_W), .DW(ENT_W)) u_ram (
    .clk(clk), .we(mreq.we), .waddr(mreq.waddr), .wdata(mreq.wdata),
    .re(mreq.re), .raddr(mreq.raddr), .rdata(rdata)
  );

  assign in_tready  = (state_r == S_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

  function automatic logic [71:0] pack_out(
    input logic [2:0] st, input logic [IDX_W-1:0] ni, input logic [GEN_W-1:0] ng,
    input logic [CNT_W-1:0] c, input logic dv, input logic [ENT_W-1:0] e);
    logic [71:0] r;
    r = '0;
    r[2:0] = st; r[8:3] = ni; r[24:9] = ng; r[29:25] = c; r[30] = dv;
    r[70:31] = e;
    return r;
  endfunction

  logic is_drain;
  assign is_drain = (op_r == OP_CLEAN) || (op_r == OP_DESTROY);

  // walk index truncated for addressing; n_r <= ITEMS
  logic [ITM_W-1:0] iw;
  assign iw  = i_r[ITM_W-1:0];

  logic hit;
  assign hit = (rdata == key_r);

  always_comb begin
    state_nxt   = state_r;
    mreq        = '0;
    mreq.raddr  = {hidx_r, iw};
    slot_re     = 1'b0;
    slot_raddr  = in_tdata[8:3];
    slot_we     = 1'b0;
    slot_waddr  = hidx_r;
    slot_wdata  = '0;
    fstk_re     = 1'b0;
    fstk_we     = 1'b0;
    case (state_r)
      S_IDLE: if (in_tvalid && in_tready) begin
        slot_re   = 1'b1;
        fstk_re   = (in_tdata[2:0] == OP_CREATE) && (ftop_r != '0);
        state_nxt = S_LOOK;
      end
      S_LOOK: begin
        if (op_r == OP_CREATE && ftop_r != '0) begin
          slot_re    = 1'b1;
          slot_raddr = fstk_rd_r;
        end
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (op_r == OP_CREATE) begin
          if (ftop_r != '0) begin
            slot_we         = 1'b1;
            slot_waddr      = fstk_rd_r;
            slot_wdata      = slot_rd_r;
            slot_wdata.live = 1'b1;
          end else if (used_r < TOP_W'(SLOTS)) begin
            slot_we         = 1'b1;
            slot_waddr      = IDX_W'(used_r);
            slot_wdata.live = 1'b1;
          end
        end else if (op_r == OP_ADD && valid_h_r && n_r < CNT_W'(ITEMS)) begin
          mreq.we = 1'b1; mreq.waddr = {hidx_r, n_r[ITM_W-1:0]}; mreq.wdata = key_r;
          slot_we         = 1'b1;
          slot_wdata.live = 1'b1;
          slot_wdata.gen  = hgen_r;
          slot_wdata.cnt  = n_r + CNT_W'(1);
        end else if (valid_h_r && is_drain) begin
          slot_we         = 1'b1;
          slot_wdata.live = (op_r == OP_CLEAN);
          slot_wdata.gen  = (op_r == OP_CLEAN) ? hgen_r : hgen_r + GEN_W'(1);
          fstk_we         = (op_r == OP_DESTROY) && (ftop_r < TOP_W'(SLOTS));
        end
        if (valid_h_r && n_r != '0 && (op_r == OP_REMOVE || is_drain)) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        mreq.re = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (op_r == OP_REMOVE) begin
          if (found_r) begin
            mreq.we = 1'b1; mreq.waddr = {hidx_r, ITM_W'(i_r - CNT_W'(1))};
            mreq.wdata = rdata;
          end
          if (i_r + CNT_W'(1) >= n_r) begin
            state_nxt = S_IDLE;
            if (found_r || hit) begin
              slot_we         = 1'b1;
              slot_wdata.live = 1'b1;
              slot_wdata.gen  = hgen_r;
              slot_wdata.cnt  = n_r - CNT_W'(1);
            end
          end else begin
            state_nxt = S_RD;
          end
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: if (!ov_r || out_tready) begin
        state_nxt = (i_r + CNT_W'(1) >= n_r) ? S_IDLE : S_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // slot table and free stack, one registered read each
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (slot_re) slot_rd_r <= slot_mem[slot_raddr];
    if (fstk_we) fstk_mem[IDX_W'(ftop_r)] <= hidx_r;
    if (fstk_re) fstk_rd_r <= fstk_mem[IDX_W'(ftop_r - TOP_W'(1))];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      ftop_r  <= '0;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (ov_r && out_tready && state_r != S_OUT) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          op_r   <= in_tdata[2:0];
          hidx_r <= in_tdata[8:3];
          hgen_r <= in_tdata[24:9];
          key_r  <= in_tdata[64:25];
          i_r    <= '0;
          found_r <= 1'b0;
        end
        S_LOOK: begin
          valid_h_r <= ({1'b0, hidx_r} < used_r) && slot_rd_r.live
                       && (slot_rd_r.gen == hgen_r);
          n_r       <= slot_rd_r.cnt;
        end
        S_EXEC: begin
          if (op_r == OP_CREATE) begin
            ov_r <= 1'b1; ol_r <= 1'b1;
            if (ftop_r != '0) begin
              ftop_r <= ftop_r - TOP_W'(1);
              od_r <= pack_out(ST_OK, fstk_rd_r, slot_rd_r.gen, '0, 1'b0, '0);
            end else if (used_r < TOP_W'(SLOTS)) begin
              used_r <= used_r + TOP_W'(1);
              od_r <= pack_out(ST_OK, IDX_W'(used_r), '0, '0, 1'b0, '0);
            end else begin
              od_r <= pack_out(ST_TFULL, '0, '0, '0, 1'b0, '0);
            end
          end else if (op_r == OP_UNUSED) begin
            ov_r <= 1'b1; ol_r <= 1'b1; od_r <= '0;
          end else if (!valid_h_r) begin
            ov_r <= 1'b1; ol_r <= 1'b1;
            od_r <= pack_out(ST_STALE, '0, '0, '0, 1'b0, '0);
          end else if (op_r == OP_ADD) begin
            ov_r <= 1'b1; ol_r <= 1'b1;
            if (n_r < CNT_W'(ITEMS)) begin
              od_r <= pack_out(ST_OK, '0, '0, n_r + CNT_W'(1), 1'b0, '0);
            end else begin
              od_r <= pack_out(ST_SFULL, '0, '0, n_r, 1'b0, '0);
            end
          end else if (op_r == OP_ALIVE || op_r == OP_COUNT) begin
            ov_r <= 1'b1; ol_r <= 1'b1;
            od_r <= pack_out(ST_OK, '0, '0, n_r, 1'b0, '0);
          end else if (op_r == OP_REMOVE) begin
            if (n_r == '0) begin
              ov_r <= 1'b1; ol_r <= 1'b1;
              od_r <= pack_out(ST_NOTFOUND, '0, '0, '0, 1'b0, '0);
            end
          end else begin
            if (n_r == '0) begin
              ov_r <= 1'b1; ol_r <= 1'b1;
              od_r <= pack_out(ST_OK, '0, '0, '0, 1'b0, '0);
            end
            if (op_r == OP_DESTROY && ftop_r < TOP_W'(SLOTS)) begin
              ftop_r <= ftop_r + TOP_W'(1);
            end
          end
        end
        S_CMP: if (op_r == OP_REMOVE) begin
          if (!found_r && hit) found_r <= 1'b1;
          i_r <= i_r + CNT_W'(1);
          if (i_r + CNT_W'(1) >= n_r) begin
            ov_r <= 1'b1; ol_r <= 1'b1;
            if (found_r || hit) begin
              od_r <= pack_out(ST_OK, '0, '0, n_r - CNT_W'(1), 1'b0, '0);
            end else begin
              od_r <= pack_out(ST_NOTFOUND, '0, '0, n_r, 1'b0, '0);
            end
          end
        end else begin
          key_r <= rdata;
        end
        S_OUT: if (!ov_r || out_tready) begin
          ov_r <= 1'b1;
          ol_r <= (i_r + CNT_W'(1) >= n_r);
          od_r <= pack_out(ST_OK, '0, '0, n_r, 1'b1, key_r);
          i_r  <= i_r + CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  `CHK_IMP(a_busy_not_ready, clk, rst_n, state_r != S_IDLE, !in_tready)
  `CHK_IMP(a_top_bound, clk, rst_n, 1'b1, ftop_r <= used_r)
  `CHK_IMP(a_walk_bound, clk, rst_n, state_r == S_RD, i_r < n_r)
  `CHK_NXT(a_out_hold, clk, rst_n, ov_r && !out_tready, ov_r && $stable(od_r))
endmodule
